// ----- rtl/cd2dn_pkg.sv -----
`timescale 1ns / 1ps
// Package for the civil date to day number converter: status codes, field
// widths, pipeline constants and calendar lookup functions. No dependencies.
package cd2dn_pkg;

  localparam int unsigned YearW    = 16;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned DayNumW  = 25;
  localparam int unsigned WeekdayW = 3;
  localparam int unsigned YearDayW = 9;
  localparam int unsigned MonLenW  = 5;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 48;

  // Biased year: y + 82 * 400 keeps the March-based year non-negative.
  localparam int unsigned YpW        = 17;
  localparam logic [16:0] YearBias   = 17'd32800;
  // floor(x / 25) for x below 4098 as (x * 1311) >> 15.
  localparam logic [10:0] Div25Mul   = 11'd1311;
  localparam int unsigned Div25Shift = 15;
  localparam int unsigned EraW       = 8;
  localparam int unsigned YoeW       = 9;
  localparam logic [8:0]  YearsPerEra = 9'd400;
  localparam logic [17:0] DaysPerEra  = 18'd146097;
  localparam int unsigned DoeW       = 18;
  // 82 * 146097 + 719468: removes the era bias and moves the epoch to 1970.
  localparam logic [25:0] EpochBias  = 26'd12699422;
  // Weekday of the biased day count is (doe + 3) mod 7, since an era is whole weeks.
  localparam logic [17:0] WeekdayOfs = 18'd3;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MONTH = 2'd1,
    ST_BAD_DAY   = 2'd2
  } status_e;

  // Days before the first of the given month, counting from March 1.
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] mon);
    logic [8:0] ofs;
    case (mon)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

  // Month length, zero for a month code outside 1..12.
  function automatic logic [MonLenW-1:0] month_days(input logic [MonthW-1:0] mon,
                                                     input logic leap);
    logic [MonLenW-1:0] len;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Leap rule on a year already reduced modulo 400.
  function automatic logic is_leap_yoe(input logic [YoeW-1:0] v);
    logic cent;
    cent = (v == 9'd100) || (v == 9'd200) || (v == 9'd300);
    return (v[1:0] == 2'b00) && !cent;
  endfunction

  // Whole centuries in a year of the era.
  function automatic logic [1:0] centuries(input logic [YoeW-1:0] v);
    logic [1:0] c;
    if (v >= 9'd300) begin
      c = 2'd3;
    end else if (v >= 9'd200) begin
      c = 2'd2;
    end else if (v >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

endpackage

// ----- rtl/civil_date_to_day_number_top.sv -----
`timescale 1ns / 1ps
// Civil date to day number converter, top level: four-stage pipeline.
// Depends on cd2dn_pkg and cd2dn_mod7.
//
// Usage:
//   The slave stream carries one proleptic Gregorian date per transaction
//   (signed year, month, day). The master stream returns one result per
//   date: a status, the signed day count since 1970-01-01, the weekday
//   (0 is Sunday), the zero-based day of the year and the month length.
//   On a bad month or day the numeric fields other than the month length
//   are zero; the month length is zero only for a bad month.
//   Each accepted date passes through four register stages before its result
//   is presented. Throughput: one date per cycle while the receiver does not
//   stall; the year-over-400 reduction, the era multiply and the day-count sum
//   each own a stage, and that split sets the depth.
//   Reset empties the pipeline; no state survives between dates.
//   When the receiver stalls, each stage holds while the one after it is
//   full; empty stages still fill, so up to four dates wait inside before
//   s_axis_tready_o drops.
module civil_date_to_day_number_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [15:0] year, [19:16] month, [24:20] day, [31:25] zero
  input  logic [cd2dn_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [1:0] status, [26:2] day_number, [29:27] weekday, [38:30] year_day,
  // [43:39] month_length, [47:44] zero
  output logic [cd2dn_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import cd2dn_pkg::*;

  // Stage valid bits and load enables.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || m_axis_tready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  // Stage 1: biased March-based year, estimate of year / 400 and day of the March-based year.
  logic [YearW-1:0]   year_in;
  logic [MonthW-1:0]  mon_in;
  logic [DayW-1:0]    day_in;
  logic               early_in;
  logic [YpW-1:0]     yp_d;
  logic [23:0]        div_prod;
  logic [EraW-1:0]    q_d;
  logic [8:0]         doy_d;

  assign year_in  = s_axis_tdata_i[15:0];
  assign mon_in   = s_axis_tdata_i[19:16];
  assign day_in   = s_axis_tdata_i[24:20];
  assign early_in = (mon_in <= 4'd2);
  assign yp_d     = {year_in[YearW-1], year_in} + YearBias - YpW'(early_in);
  assign div_prod = 24'(yp_d[YpW-1:4]) * 24'(Div25Mul);
  assign q_d      = div_prod[Div25Shift+EraW-1:Div25Shift];
  assign doy_d    = month_offset(mon_in) + 9'(day_in) - 9'd1;

  logic [YpW-1:0]    yp1_q;
  logic [EraW-1:0]   q1_q;
  logic [MonthW-1:0] mon1_q;
  logic [DayW-1:0]   day1_q;
  logic [8:0]        doy1_q;

  // Stage 2: exact era and year of era.
  logic [YpW-1:0]    rem_full;
  logic              rem_over;
  logic [EraW-1:0]   era_d;
  logic [YoeW-1:0]   yoe_d;

  assign rem_full = yp1_q - YpW'(q1_q) * YpW'(YearsPerEra);
  assign rem_over = (rem_full >= YpW'(YearsPerEra));
  assign era_d    = rem_over ? q1_q + 8'd1 : q1_q;
  assign yoe_d    = rem_over ? YoeW'(rem_full - YpW'(YearsPerEra)) : YoeW'(rem_full);

  logic [EraW-1:0]   era2_q;
  logic [YoeW-1:0]   yoe2_q;
  logic [MonthW-1:0] mon2_q;
  logic [DayW-1:0]   day2_q;
  logic [8:0]        doy2_q;

  // Stage 3: validation, day of era, day of year and era product.
  logic              leap_y;
  logic [YoeW-1:0]   ymod;
  logic              leap_yr;
  logic [MonLenW-1:0] mlen_d;
  status_e           status_d;
  logic [DoeW-1:0]   doe_d;
  logic [DayNumW-1:0] prod_d;
  logic [YearDayW-1:0] yday_d;

  assign leap_y  = is_leap_yoe(yoe2_q);
  // For January and February the civil year is one past the March-based year.
  assign ymod    = (mon2_q <= 4'd2) ? ((yoe2_q == 9'd399) ? 9'd0 : yoe2_q + 9'd1) : yoe2_q;
  assign leap_yr = is_leap_yoe(ymod);
  assign mlen_d  = month_days(mon2_q, leap_yr);

  always_comb begin
    if (mon2_q == 4'd0 || mon2_q > 4'd12) begin
      status_d = ST_BAD_MONTH;
    end else if (day2_q == 5'd0 || day2_q > mlen_d) begin
      status_d = ST_BAD_DAY;
    end else begin
      status_d = ST_OK;
    end
  end

  assign doe_d  = DoeW'(yoe2_q) * 18'd365 + DoeW'(yoe2_q[YoeW-1:2])
                - DoeW'(centuries(yoe2_q)) + DoeW'(doy2_q);
  assign prod_d = DayNumW'(era2_q) * DayNumW'(DaysPerEra);
  assign yday_d = (doy2_q > 9'd305) ? doy2_q - 9'd306
                                    : doy2_q + 9'd59 + 9'(leap_y);

  logic [DayNumW-1:0]  prod3_q;
  logic [DoeW-1:0]     doe3_q;
  status_e             status3_q;
  logic [MonLenW-1:0]  mlen3_q;
  logic [YearDayW-1:0] yday3_q;

  // Stage 4: day number, weekday and masking of bad dates.
  logic [25:0]         z_full;
  logic [WeekdayW-1:0] wd_d;
  logic                ok3;

  assign z_full = 26'(prod3_q) + 26'(doe3_q) - EpochBias;
  assign ok3    = (status3_q == ST_OK);

  cd2dn_mod7 u_mod7 (
    .x_i (doe3_q + WeekdayOfs),
    .r_o (wd_d)
  );

  status_e             status4_q;
  logic [DayNumW-1:0]  dn4_q;
  logic [WeekdayW-1:0] wd4_q;
  logic [YearDayW-1:0] yday4_q;
  logic [MonLenW-1:0]  mlen4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      yp1_q  <= yp_d;
      q1_q   <= q_d;
      mon1_q <= mon_in;
      day1_q <= day_in;
      doy1_q <= doy_d;
    end
    if (en2) begin
      era2_q <= era_d;
      yoe2_q <= yoe_d;
      mon2_q <= mon1_q;
      day2_q <= day1_q;
      doy2_q <= doy1_q;
    end
    if (en3) begin
      prod3_q   <= prod_d;
      doe3_q    <= doe_d;
      status3_q <= status_d;
      mlen3_q   <= mlen_d;
      yday3_q   <= yday_d;
    end
    if (en4) begin
      status4_q <= status3_q;
      dn4_q     <= ok3 ? z_full[DayNumW-1:0] : '0;
      wd4_q     <= ok3 ? wd_d : '0;
      yday4_q   <= ok3 ? yday3_q : '0;
      mlen4_q   <= mlen3_q;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {4'd0, mlen4_q, yday4_q, wd4_q, dn4_q, status4_q};

endmodule

// ----- rtl/cd2dn_mod7.sv -----
`timescale 1ns / 1ps
// Remainder modulo 7 of an 18-bit count by folding octal digits (8 = 1 mod 7).
// Uses cd2dn_pkg for widths.
module cd2dn_mod7 (
  input  logic [cd2dn_pkg::DoeW-1:0]     x_i,
  output logic [cd2dn_pkg::WeekdayW-1:0] r_o
);
  import cd2dn_pkg::*;

  logic [5:0] digit_sum;
  logic [3:0] fold;

  assign digit_sum = 6'(x_i[2:0]) + 6'(x_i[5:3]) + 6'(x_i[8:6])
                   + 6'(x_i[11:9]) + 6'(x_i[14:12]) + 6'(x_i[17:15]);
  assign fold = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
  assign r_o  = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];

endmodule

// ----- rtl/cd2dn_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the civil date converter, bound to the top level.
// Depends on cd2dn_pkg and civil_date_to_day_number_top.
module cd2dn_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_tvalid_i,
  input logic                           m_tready_i,
  input logic [cd2dn_pkg::OutDataW-1:0] m_tdata_i
);
  import cd2dn_pkg::*;

  logic [StatusW-1:0]  st;
  logic [DayNumW-1:0]  dn;
  logic [WeekdayW-1:0] wd;
  logic [YearDayW-1:0] yd;
  logic [MonLenW-1:0]  ml;

  assign st = m_tdata_i[1:0];
  assign dn = m_tdata_i[26:2];
  assign wd = m_tdata_i[29:27];
  assign yd = m_tdata_i[38:30];
  assign ml = m_tdata_i[43:39];

  // A stalled result must stay put until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result changed while stalled");

  a_bad_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && st == ST_BAD_MONTH |-> dn == '0 && wd == '0 && yd == '0 && ml == '0)
    else $error("bad month result not cleared");

  a_bad_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && st == ST_BAD_DAY |-> dn == '0 && wd == '0 && yd == '0 && ml >= 5'd28)
    else $error("bad day result not cleared");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (st == ST_OK && wd <= 3'd6 && yd <= 9'd365 && ml >= 5'd28)
                   || st == ST_BAD_MONTH || st == ST_BAD_DAY)
    else $error("result fields out of range");

endmodule

bind civil_date_to_day_number_top cd2dn_checker u_cd2dn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
